### design/pabu_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helper functions for the pixel art block upscaler
package pabu_pkg;

	localparam int PIX_W  = 32;
	localparam int CH_W   = 8;
	localparam int N_CH   = 4;
	localparam int N_COL  = 3;
	localparam int DIST_W = 20;
	localparam int CRD_W  = 3;
	localparam int N_PAIR = 8;

	localparam int CRN_TL = 0;
	localparam int CRN_TR = 1;
	localparam int CRN_BL = 2;
	localparam int CRN_BR = 3;

	typedef logic [PIX_W-1:0]  pix_t;
	typedef logic [CH_W-1:0]   chan_t;
	typedef logic [DIST_W-1:0] dist_t;
	typedef logic [CRD_W-1:0]  coord_t;

	typedef enum logic [1:0] {
		MODE_PASS,
		MODE_X2,
		MODE_X3,
		MODE_X5
	} mode_t;

	// cell positions used by the wider border cells of the 5x block
	localparam coord_t X5_NEAR = 3'd1;
	localparam coord_t X5_FAR  = 3'd3;
	localparam coord_t X5_LAST = 3'd4;

	// one classified source pixel, ready for the output sequencer
	typedef struct packed {
		mode_t          mode;
		pix_t           center;
		pix_t [3:0]     corner;
		pix_t [3:0]     side;
	} job_t;

	function automatic pix_t avg_px(pix_t x, pix_t y);
		logic [CH_W:0] s;
		pix_t          r;
		r = '0;
		for (int k = 0; k < N_CH; k++) begin
			s = {1'b0, x[k*CH_W +: CH_W]} + {1'b0, y[k*CH_W +: CH_W]};
			r[k*CH_W +: CH_W] = s[CH_W:1];
		end
		return r;
	endfunction

	function automatic chan_t abs_diff(chan_t a, chan_t b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	function automatic coord_t last_idx(mode_t m);
		coord_t r;
		case (m)
			MODE_PASS: r = 3'd0;
			MODE_X2:   r = 3'd1;
			MODE_X3:   r = 3'd2;
			MODE_X5:   r = 3'd4;
			default:   r = 3'd0;
		endcase
		return r;
	endfunction

endpackage

### design/pabu_ifs.sv
`timescale 1ns / 1ps
// request channel interfaces: neighbourhood input, pixel output and mode register write
interface pabu_in_if;
	import pabu_pkg::*;
	logic valid;
	logic ready;
	pix_t px_up_left;
	pix_t px_up;
	pix_t px_up_right;
	pix_t px_left;
	pix_t px_center;
	pix_t px_right;
	pix_t px_down_left;
	pix_t px_down;
	pix_t px_down_right;

	modport source (
		output valid, px_up_left, px_up, px_up_right, px_left, px_center,
		       px_right, px_down_left, px_down, px_down_right,
		input  ready
	);
	modport sink (
		input  valid, px_up_left, px_up, px_up_right, px_left, px_center,
		       px_right, px_down_left, px_down, px_down_right,
		output ready
	);
endinterface

interface pabu_out_if;
	import pabu_pkg::*;
	logic   valid;
	logic   ready;
	pix_t   out_pixel;
	coord_t sub_col;
	coord_t sub_row;
	logic   block_end;

	modport source (
		output valid, out_pixel, sub_col, sub_row, block_end,
		input  ready
	);
	modport sink (
		input  valid, out_pixel, sub_col, sub_row, block_end,
		output ready
	);
endinterface

interface pabu_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] scale_mode;

	modport source (
		output valid, scale_mode,
		input  ready
	);
	modport sink (
		input  valid, scale_mode,
		output ready
	);
endinterface

### design/pabu_front.sv
`timescale 1ns / 1ps
// front end: accepts neighbourhoods, tests the corners and resolves the replacement pixels
module pabu_front (
	input  logic            clk,
	input  logic            arst_n,
	input  pabu_pkg::mode_t mode,
	pabu_in_if.sink         pix_in,
	output logic            push_valid,
	input  logic            push_ready,
	output pabu_pkg::job_t  push_data
);
	import pabu_pkg::*;

	logic  adv_s1;
	logic  adv_s2;
	pix_t  pair_a [N_PAIR];
	pix_t  pair_b [N_PAIR];
	logic  [3:0] fire_nx;
	dist_t dist_nx [N_PAIR];

	logic       valid_s1;
	mode_t      mode_s1;
	pix_t       p_s1;
	pix_t       b_s1;
	pix_t       d_s1;
	pix_t       f_s1;
	logic [3:0] fire_s1;
	chan_t      diff_s1 [N_PAIR][N_COL];

	logic       valid_s2;
	mode_t      mode_s2;
	pix_t       p_s2;
	pix_t       b_s2;
	pix_t       d_s2;
	pix_t       f_s2;
	logic [3:0] fire_s2;
	dist_t      dist_s2 [N_PAIR];

	logic [3:0] closer;
	pix_t       avg_pb;
	pix_t       avg_pd;
	pix_t       avg_pf;

	always_comb begin
		adv_s2       = !valid_s2 || push_ready;
		adv_s1       = !valid_s1 || adv_s2;
		pix_in.ready = adv_s1;
	end

	// distance pairs: each corner compares its diagonal to the centre against the opposite pair
	always_comb begin
		pair_a[0] = pix_in.px_up_left;   pair_b[0] = pix_in.px_center;
		pair_a[1] = pix_in.px_up;        pair_b[1] = pix_in.px_up_right;
		pair_a[2] = pix_in.px_up_right;  pair_b[2] = pix_in.px_center;
		pair_a[3] = pix_in.px_up;        pair_b[3] = pix_in.px_up_left;
		pair_a[4] = pix_in.px_down_left; pair_b[4] = pix_in.px_center;
		pair_a[5] = pix_in.px_left;      pair_b[5] = pix_in.px_up_left;
		pair_a[6] = pix_in.px_down_right; pair_b[6] = pix_in.px_center;
		pair_a[7] = pix_in.px_right;     pair_b[7] = pix_in.px_up_right;
	end

	always_comb begin
		fire_nx[CRN_TL] = (pix_in.px_up == pix_in.px_left) &&
			(pix_in.px_up != pix_in.px_right) && (pix_in.px_left != pix_in.px_down);
		fire_nx[CRN_TR] = (pix_in.px_up == pix_in.px_right) &&
			(pix_in.px_up != pix_in.px_left) && (pix_in.px_right != pix_in.px_down);
		fire_nx[CRN_BL] = (pix_in.px_left == pix_in.px_down) &&
			(pix_in.px_left != pix_in.px_up) && (pix_in.px_down != pix_in.px_right);
		fire_nx[CRN_BR] = (pix_in.px_right == pix_in.px_down) &&
			(pix_in.px_right != pix_in.px_up) && (pix_in.px_down != pix_in.px_left);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= pix_in.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && pix_in.valid) begin
			mode_s1 <= mode;
			p_s1    <= pix_in.px_center;
			b_s1    <= pix_in.px_up;
			d_s1    <= pix_in.px_left;
			f_s1    <= pix_in.px_right;
			fire_s1 <= fire_nx;
			for (int k = 0; k < N_PAIR; k++) begin
				for (int c = 0; c < N_COL; c++) begin
					diff_s1[k][c] <= abs_diff(pair_a[k][c*CH_W +: CH_W],
						pair_b[k][c*CH_W +: CH_W]);
				end
			end
		end
	end

	// weighted distance: 2 for red, 4 for green, 3 for blue
	always_comb begin
		logic [2*CH_W-1:0] sq [N_COL];
		for (int k = 0; k < N_PAIR; k++) begin
			for (int c = 0; c < N_COL; c++) begin
				sq[c] = {8'd0, diff_s1[k][c]} * {8'd0, diff_s1[k][c]};
			end
			dist_nx[k] = DIST_W'({sq[0], 1'b0}) + DIST_W'({sq[1], 2'b00})
				+ DIST_W'({sq[2], 1'b0}) + DIST_W'(sq[2]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			mode_s2 <= mode_s1;
			p_s2    <= p_s1;
			b_s2    <= b_s1;
			d_s2    <= d_s1;
			f_s2    <= f_s1;
			fire_s2 <= fire_s1;
			for (int k = 0; k < N_PAIR; k++) begin
				dist_s2[k] <= dist_nx[k];
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			closer[k] = dist_s2[2*k] < dist_s2[2*k+1];
		end
		avg_pb = avg_px(p_s2, b_s2);
		avg_pd = avg_px(p_s2, d_s2);
		avg_pf = avg_px(p_s2, f_s2);
	end

	always_comb begin
		push_valid       = valid_s2;
		push_data.mode   = mode_s2;
		push_data.center = p_s2;
		push_data.corner = {4{p_s2}};
		push_data.side   = {4{p_s2}};
		case (mode_s2)
			MODE_PASS: begin
			end
			MODE_X2: begin
				if (fire_s2[CRN_TL]) push_data.corner[CRN_TL] = closer[CRN_TL] ? avg_pb : b_s2;
				if (fire_s2[CRN_TR]) push_data.corner[CRN_TR] = closer[CRN_TR] ? avg_pb : b_s2;
				if (fire_s2[CRN_BL]) push_data.corner[CRN_BL] = closer[CRN_BL] ? avg_pd : d_s2;
				if (fire_s2[CRN_BR]) push_data.corner[CRN_BR] = closer[CRN_BR] ? avg_pf : f_s2;
			end
			MODE_X3, MODE_X5: begin
				if (fire_s2[CRN_TL]) begin
					push_data.corner[CRN_TL] = d_s2;
					push_data.side[CRN_TL]   = avg_pd;
				end
				if (fire_s2[CRN_TR]) begin
					push_data.corner[CRN_TR] = f_s2;
					push_data.side[CRN_TR]   = avg_pf;
				end
				if (fire_s2[CRN_BL]) begin
					push_data.corner[CRN_BL] = d_s2;
					push_data.side[CRN_BL]   = avg_pd;
				end
				if (fire_s2[CRN_BR]) begin
					push_data.corner[CRN_BR] = f_s2;
					push_data.side[CRN_BR]   = avg_pf;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

### design/pabu_fifo.sv
`timescale 1ns / 1ps
// short queue of classified pixels between the front end and the output sequencer
module pabu_fifo #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  pabu_pkg::job_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output pabu_pkg::job_t pop_data
);
	import pabu_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          entry_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push_fire;
	logic          pop_fire;

	always_comb begin
		push_ready = count_q != CW'(DEPTH);
		pop_valid  = count_q != '0;
		push_fire  = push_valid && push_ready;
		pop_fire   = pop_valid && pop_ready;
		pop_data   = entry_q[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_fire) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_fire && !pop_fire) begin
				count_q <= count_q + 1'b1;
			end else if (pop_fire && !push_fire) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_fire) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue fill above depth");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push_fire && !pop_fire) |=> count_q == CW'($past(count_q) + 1'b1))
		else $error("queue fill lost a push");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_fire && !push_fire) |=> count_q == CW'($past(count_q) - 1'b1))
		else $error("queue fill lost a pop");
`endif

endmodule

### design/pabu_back.sv
`timescale 1ns / 1ps
// output sequencer: walks the block in raster order and drives the output register
module pabu_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pop_valid,
	output logic           pop_ready,
	input  pabu_pkg::job_t pop_data,
	pabu_out_if.source     pix_out
);
	import pabu_pkg::*;

	job_t   job_q;
	logic   busy_q;
	coord_t row_q;
	coord_t col_q;

	logic   out_valid_q;
	pix_t   out_pixel_q;
	coord_t sub_col_q;
	coord_t sub_row_q;
	logic   block_end_q;

	coord_t lst;
	logic   out_adv;
	logic   emit;
	logic   row_end;
	logic   at_end;
	logic   pop_fire;
	logic   x5;
	pix_t   sel;

	always_comb begin
		lst       = last_idx(job_q.mode);
		out_adv   = !out_valid_q || pix_out.ready;
		emit      = busy_q && out_adv;
		row_end   = col_q == lst;
		at_end    = row_end && (row_q == lst);
		pop_ready = !busy_q || (emit && at_end);
		pop_fire  = pop_valid && pop_ready;
		x5        = job_q.mode == MODE_X5;
	end

	always_comb begin
		sel = job_q.center;
		if (row_q == '0 && col_q == '0) begin
			sel = job_q.corner[CRN_TL];
		end else if (row_q == '0 && col_q == lst) begin
			sel = job_q.corner[CRN_TR];
		end else if (row_q == lst && col_q == '0) begin
			sel = job_q.corner[CRN_BL];
		end else if (row_q == lst && col_q == lst) begin
			sel = job_q.corner[CRN_BR];
		end else if (x5) begin
			if ((row_q == '0 && col_q == X5_NEAR) || (row_q == X5_NEAR && col_q == '0)) begin
				sel = job_q.side[CRN_TL];
			end else if ((row_q == '0 && col_q == X5_FAR) ||
				(row_q == X5_NEAR && col_q == X5_LAST)) begin
				sel = job_q.side[CRN_TR];
			end else if ((row_q == X5_LAST && col_q == X5_NEAR) ||
				(row_q == X5_FAR && col_q == '0)) begin
				sel = job_q.side[CRN_BL];
			end else if ((row_q == X5_LAST && col_q == X5_FAR) ||
				(row_q == X5_FAR && col_q == X5_LAST)) begin
				sel = job_q.side[CRN_BR];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			row_q       <= '0;
			col_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop_fire) begin
				busy_q <= 1'b1;
				row_q  <= '0;
				col_q  <= '0;
			end else if (emit) begin
				if (at_end) begin
					busy_q <= 1'b0;
				end else if (row_end) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			if (out_adv) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_fire) begin
			job_q <= pop_data;
		end
		if (emit) begin
			out_pixel_q <= sel;
			sub_col_q   <= col_q;
			sub_row_q   <= row_q;
			block_end_q <= at_end;
		end
	end

	always_comb begin
		pix_out.valid     = out_valid_q;
		pix_out.out_pixel = out_pixel_q;
		pix_out.sub_col   = sub_col_q;
		pix_out.sub_row   = sub_row_q;
		pix_out.block_end = block_end_q;
	end

`ifndef SYNTHESIS
	a_end_square: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && block_end_q) |-> sub_col_q == sub_row_q)
		else $error("block end off the diagonal");

	a_coord_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (row_q <= lst) && (col_q <= lst))
		else $error("sequencer position outside block");

	a_load_origin: assert property (@(posedge clk) disable iff (!arst_n)
		pop_fire |=> busy_q && row_q == '0 && col_q == '0)
		else $error("new block not started at origin");
`endif

endmodule

### design/pixel_art_block_upscaler.sv
`timescale 1ns / 1ps
// top level of the pixel art block upscaler
//
// pix_in carries one source pixel with its clamped 3x3 neighbourhood per request;
// pix_out returns the scaled block one pixel per request in raster order, with
// sub_col, sub_row and block_end marking the position and the final pixel.
// cfg writes scale_mode (pass-through, 2x, 3x, 5x); it is always ready and
// must only be written while no block is in flight.
// a request passes front end stages s1 and s2, the queue, the sequencer job
// register and the output register. throughput: one output pixel per cycle
// while the receiver is ready; a source pixel gives 1, 4, 9 or 25 pixels, set
// by the sequencer that walks the block through the single output register.
// the front end, a two-stage pipeline, feeds a short queue, so new neighbourhoods
// are taken while a block is still being sent. a stalled receiver holds the
// output register; the queue then fills and pix_in.ready drops.
// reset empties the pipeline, queue and sequencer and sets scale_mode to 2x.
module pixel_art_block_upscaler #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	pabu_in_if.sink    pix_in,
	pabu_out_if.source pix_out,
	pabu_cfg_if.sink   cfg
);
	import pabu_pkg::*;

	mode_t scale_mode_q;
	logic  push_valid;
	logic  push_ready;
	job_t  push_data;
	logic  pop_valid;
	logic  pop_ready;
	job_t  pop_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_mode_q <= MODE_X2;
		end else if (cfg.valid) begin
			scale_mode_q <= mode_t'(cfg.scale_mode);
		end
	end

	pabu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode       (scale_mode_q),
		.pix_in     (pix_in),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	pabu_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	pabu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.pix_out   (pix_out)
	);

endmodule
